// ----- hw/rtl/dns_query_packet_builder_unit_assert.svh -----
// assertion macros for the dns query packet builder
`ifndef DNS_QUERY_PACKET_BUILDER_UNIT_ASSERT_SVH
`define DNS_QUERY_PACKET_BUILDER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define DQB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define DQB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQB_ASSERT(lbl, clk, rst, prop, msg)
`define DQB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/dqb_pkg.sv -----
// shared types, constants and byte tables of the dns query packet builder
package dqb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_LEN,
    ST_LABEL,
    ST_FOOTER
  } state_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_DOT,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    SRC_HEADER,
    SRC_LEN,
    SRC_LABEL,
    SRC_FOOTER
  } src_t;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] END_CHAR = 8'h00;
  localparam logic [7:0] BYTE_ONE = 8'h01;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] HEADER_LAST = 4'd11;
  localparam logic [POS_W-1:0] FOOTER_LAST = 4'd4;

  // header byte positions that are not fixed at zero
  localparam logic [POS_W-1:0] POS_ID_HI = 4'd0;
  localparam logic [POS_W-1:0] POS_ID_LO = 4'd1;
  localparam logic [POS_W-1:0] POS_FLAGS_HI = 4'd2;
  localparam logic [POS_W-1:0] POS_QDCOUNT_LO = 4'd5;
  // footer byte positions that are one
  localparam logic [POS_W-1:0] POS_QTYPE_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_QCLASS_LO = 4'd4;

  typedef struct packed {
    logic accept;
    logic emit;
    src_t src;
    logic pos_clr;
    logic pos_inc;
    logic idx_clr;
    logic idx_inc;
    logic run_last;
    logic pkt_end;
  } cmd_t;

  typedef struct packed {
    kind_t in_kind;
    kind_t kind;
    logic  header_sent;
    logic  cur_label_nz;
    logic  emit_nz;
    logic  pos_hdr_last;
    logic  pos_ftr_last;
    logic  idx_last;
    logic  out_free;
  } status_t;

  function automatic logic [7:0] header_byte(input logic [POS_W-1:0] pos,
                                             input logic [15:0] id);
    logic [7:0] b;
    b = BYTE_ZERO;
    if (pos == POS_ID_HI) begin
      b = id[15:8];
    end else if (pos == POS_ID_LO) begin
      b = id[7:0];
    end else if (pos == POS_FLAGS_HI || pos == POS_QDCOUNT_LO) begin
      b = BYTE_ONE;
    end
    return b;
  endfunction

  function automatic logic [7:0] footer_byte(input logic [POS_W-1:0] pos);
    logic [7:0] b;
    b = BYTE_ZERO;
    if (pos == POS_QTYPE_LO || pos == POS_QCLASS_LO) begin
      b = BYTE_ONE;
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/dqb_ctrl.sv -----
// controller state machine: sequences header, length, label and footer bytes
module dqb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dqb_pkg::status_t st,
  output dqb_pkg::cmd_t    cmd
);

  dqb_pkg::state_t state;
  dqb_pkg::state_t state_next;

  // where an item goes once the header is out (or was already out)
  function automatic dqb_pkg::state_t after_header(input dqb_pkg::kind_t k,
                                                   input logic label_nz);
    dqb_pkg::state_t s;
    s = dqb_pkg::ST_IDLE;
    unique case (k)
      dqb_pkg::KIND_END: s = label_nz ? dqb_pkg::ST_LEN : dqb_pkg::ST_FOOTER;
      dqb_pkg::KIND_DOT: s = label_nz ? dqb_pkg::ST_LEN : dqb_pkg::ST_IDLE;
      default:           s = dqb_pkg::ST_IDLE;
    endcase
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dqb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dqb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = st.header_sent ? after_header(st.in_kind, st.cur_label_nz)
                                      : dqb_pkg::ST_HEADER;
        end
      end
      dqb_pkg::ST_HEADER: begin
        if (st.out_free && st.pos_hdr_last) begin
          state_next = after_header(st.kind, st.emit_nz);
        end
      end
      dqb_pkg::ST_LEN: begin
        if (st.out_free) begin
          state_next = dqb_pkg::ST_LABEL;
        end
      end
      dqb_pkg::ST_LABEL: begin
        if (st.out_free && st.idx_last) begin
          state_next = (st.kind == dqb_pkg::KIND_END) ? dqb_pkg::ST_FOOTER
                                                      : dqb_pkg::ST_IDLE;
        end
      end
      dqb_pkg::ST_FOOTER: begin
        if (st.out_free && st.pos_ftr_last) begin
          state_next = dqb_pkg::ST_IDLE;
        end
      end
      default: state_next = dqb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    cmd.src = dqb_pkg::SRC_HEADER;
    unique case (state)
      dqb_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      dqb_pkg::ST_HEADER: begin
        cmd.emit = st.out_free;
        cmd.src  = dqb_pkg::SRC_HEADER;
        if (st.out_free) begin
          if (st.pos_hdr_last) begin
            cmd.pos_clr  = 1'b1;
            cmd.run_last = (after_header(st.kind, st.emit_nz) == dqb_pkg::ST_IDLE);
          end else begin
            cmd.pos_inc = 1'b1;
          end
        end
      end
      dqb_pkg::ST_LEN: begin
        cmd.emit = st.out_free;
        cmd.src  = dqb_pkg::SRC_LEN;
      end
      dqb_pkg::ST_LABEL: begin
        cmd.emit = st.out_free;
        cmd.src  = dqb_pkg::SRC_LABEL;
        if (st.out_free) begin
          if (st.idx_last) begin
            cmd.idx_clr  = 1'b1;
            cmd.run_last = (st.kind != dqb_pkg::KIND_END);
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      dqb_pkg::ST_FOOTER: begin
        cmd.emit = st.out_free;
        cmd.src  = dqb_pkg::SRC_FOOTER;
        if (st.out_free) begin
          if (st.pos_ftr_last) begin
            cmd.pos_clr  = 1'b1;
            cmd.run_last = 1'b1;
            cmd.pkt_end  = 1'b1;
          end else begin
            cmd.pos_inc = 1'b1;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dqb_datapath.sv -----
// datapath: label buffer, query id, byte counters and output register
module dqb_datapath #(
  parameter int MAX_LABEL = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       in_char,
  input  logic             cfg_valid,
  input  logic [15:0]      cfg_data,
  input  dqb_pkg::cmd_t    cmd,
  output dqb_pkg::status_t st,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [1:0]       out_user
);

  localparam int CNT_W = $clog2(MAX_LABEL + 1);
  localparam int IDX_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  logic [15:0]              query_id;
  logic [7:0]               label_mem [MAX_LABEL];
  logic [7:0]               rd_byte;
  logic [CNT_W-1:0]         label_count;
  logic [CNT_W-1:0]         emit_len;
  logic                     header_sent;
  logic                     overflow_seen;
  logic                     ovf_flag;
  dqb_pkg::kind_t           kind;
  dqb_pkg::kind_t           in_kind;
  logic [dqb_pkg::POS_W-1:0] pos;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_next;
  logic                     out_free;
  logic [7:0]               byte_sel;
  logic                     buf_room;

  assign in_kind = (in_char == dqb_pkg::DOT_CHAR) ? dqb_pkg::KIND_DOT :
                   (in_char == dqb_pkg::END_CHAR) ? dqb_pkg::KIND_END :
                                                    dqb_pkg::KIND_CHAR;
  assign buf_room = (label_count < CNT_W'(MAX_LABEL));
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_id <= '0;
    end else if (cfg_valid) begin
      query_id <= cfg_data;
    end
  end

  // label buffer and per-query state
  always_ff @(posedge clk) begin
    if (rst) begin
      label_count   <= '0;
      emit_len      <= '0;
      header_sent   <= 1'b0;
      overflow_seen <= 1'b0;
      ovf_flag      <= 1'b0;
      kind          <= dqb_pkg::KIND_CHAR;
    end else if (cmd.accept) begin
      kind        <= in_kind;
      ovf_flag    <= overflow_seen;
      header_sent <= (in_kind != dqb_pkg::KIND_END);
      if (in_kind == dqb_pkg::KIND_CHAR) begin
        if (buf_room) begin
          label_count <= label_count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end else begin
        // label moves to the replay side, buffer starts over
        emit_len      <= label_count;
        label_count   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_kind == dqb_pkg::KIND_CHAR && buf_room) begin
      label_mem[label_count[IDX_W-1:0]] <= in_char;
    end
  end

  // read port follows the index it will hold, so rd_byte always matches idx
  always_comb begin
    idx_next = idx;
    if (cmd.accept || cmd.idx_clr) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_byte <= label_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      pos <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.accept || cmd.pos_clr) begin
        pos <= '0;
      end else if (cmd.pos_inc) begin
        pos <= pos + dqb_pkg::POS_W'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd.src)
      dqb_pkg::SRC_HEADER: byte_sel = dqb_pkg::header_byte(pos, query_id);
      dqb_pkg::SRC_LEN:    byte_sel = 8'(emit_len);
      dqb_pkg::SRC_LABEL:  byte_sel = rd_byte;
      dqb_pkg::SRC_FOOTER: byte_sel = dqb_pkg::footer_byte(pos);
      default:             byte_sel = dqb_pkg::BYTE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= byte_sel;
      out_last    <= cmd.run_last;
      out_user[0] <= cmd.pkt_end;
      out_user[1] <= (cmd.src != dqb_pkg::SRC_HEADER) && ovf_flag;
    end
  end

  always_comb begin
    st.in_kind      = in_kind;
    st.kind         = kind;
    st.header_sent  = header_sent;
    st.cur_label_nz = (label_count != '0);
    st.emit_nz      = (emit_len != '0);
    st.pos_hdr_last = (pos == dqb_pkg::HEADER_LAST);
    st.pos_ftr_last = (pos == dqb_pkg::FOOTER_LAST);
    st.idx_last     = ((CNT_W'(idx) + CNT_W'(1)) == emit_len);
    st.out_free     = out_free;
  end

endmodule

// ----- hw/rtl/dns_query_packet_builder_unit.sv -----
// top level of the dns query packet builder
//
//   channel   direction  payload
//   s_axis    in         tdata = name_char
//   m_axis    out        tdata = out_byte, tlast = run_last,
//                        tuser = packet_end, label_overflow
//   cfg       in         data = query_id
//
// an item is taken while the sequencer is idle, then each byte it produces passes
// through the output register; a plain character after the header produces no byte
// ready stays low while bytes of the previous item are still being produced,
// so a new item is not taken until every byte of the previous item is sequenced
// a stall on m_axis holds the sequencer in place; nothing is dropped
// synchronous reset clears the sequencer and per-query state, not the buffer
`include "dns_query_packet_builder_unit_assert.svh"

module dns_query_packet_builder_unit #(
  parameter int MAX_LABEL = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] name_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [0] packet_end, [1] label_overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dqb_pkg::cmd_t    cmd;
  dqb_pkg::status_t st;

  assign cfg_ready = 1'b1;

  dqb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dqb_datapath #(
    .MAX_LABEL (MAX_LABEL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_char   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_user  (m_axis_tuser)
  );

  `DQB_ASSERT(a_emit_needs_room, clk, rst, cmd.emit |-> st.out_free, "byte emitted into a full output register")
  `DQB_ASSERT(a_no_emit_while_taking, clk, rst, s_axis_tready |-> !cmd.emit, "byte emitted while taking an item")
  `DQB_ASSERT(a_end_is_last, clk, rst, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast, "packet end without run last")
  `DQB_ASSERT(a_emit_fills, clk, rst, cmd.emit |=> m_axis_tvalid, "emitted byte not presented")

endmodule

// ----- test/dns_query_packet_builder_unit_tb.sv -----
// testbench of the dns query packet builder: directed and random host names checked against a byte predictor
`timescale 1ns / 1ps

module dns_query_packet_builder_unit_tb;

  localparam int NAME_LABEL_MAX = 32;
  // worst item: header, length byte, full label and footer, plus margin
  localparam int SETTLE_CYCLES = 1 + 13 + NAME_LABEL_MAX + 5 + 10;
  localparam int RANDOM_ITEMS = 150;

  class dns_query_scoreboard #(int LABEL_MAX = 32);
    typedef struct {
      logic [7:0] out_byte;
      bit         run_last;
      bit         packet_end;
      bit         label_overflow;
    } wire_byte_t;

    logic [7:0]  label_buf [LABEL_MAX];
    int unsigned label_len;
    bit          in_query;
    bit          dropped_chars;
    logic [15:0] query_id;
    wire_byte_t  pending [$];
    wire_byte_t  step_bytes [$];
    int          errors;

    function new();
      label_len = 0;
      in_query = 1'b0;
      dropped_chars = 1'b0;
      query_id = 16'h0000;
      errors = 0;
    endfunction

    function void set_query_id(logic [15:0] id);
      query_id = id;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    function dqb_pkg::kind_t classify(logic [7:0] c);
      if (c == dqb_pkg::DOT_CHAR) begin
        return dqb_pkg::KIND_DOT;
      end else if (c == dqb_pkg::END_CHAR) begin
        return dqb_pkg::KIND_END;
      end
      return dqb_pkg::KIND_CHAR;
    endfunction

    function void add_byte(logic [7:0] b, bit ovf);
      wire_byte_t w;
      w.out_byte = b;
      w.run_last = 1'b0;
      w.packet_end = 1'b0;
      w.label_overflow = ovf;
      step_bytes.push_back(w);
    endfunction

    function void add_label(bit ovf);
      if (label_len == 0) begin
        return;
      end
      add_byte(label_len[7:0], ovf);
      for (int i = 0; i < label_len; i++) begin
        add_byte(label_buf[i], ovf);
      end
      label_len = 0;
      dropped_chars = 1'b0;
    endfunction

    function void note_char(logic [7:0] c);
      bit ovf;
      bit ends;
      wire_byte_t w;
      ovf = dropped_chars;
      ends = 1'b0;
      step_bytes.delete();
      if (!in_query) begin
        add_byte(query_id[15:8], 1'b0);
        add_byte(query_id[7:0], 1'b0);
        add_byte(dqb_pkg::BYTE_ONE, 1'b0);
        add_byte(dqb_pkg::BYTE_ZERO, 1'b0);
        add_byte(dqb_pkg::BYTE_ZERO, 1'b0);
        add_byte(dqb_pkg::BYTE_ONE, 1'b0);
        for (int i = 0; i < 6; i++) begin
          add_byte(dqb_pkg::BYTE_ZERO, 1'b0);
        end
        in_query = 1'b1;
      end
      case (classify(c))
        dqb_pkg::KIND_DOT: begin
          add_label(ovf);
        end
        dqb_pkg::KIND_END: begin
          add_label(ovf);
          // root byte, then qtype and qclass
          add_byte(dqb_pkg::BYTE_ZERO, ovf);
          add_byte(dqb_pkg::BYTE_ZERO, ovf);
          add_byte(dqb_pkg::BYTE_ONE, ovf);
          add_byte(dqb_pkg::BYTE_ZERO, ovf);
          add_byte(dqb_pkg::BYTE_ONE, ovf);
          ends = 1'b1;
        end
        default: begin
          if (label_len < LABEL_MAX) begin
            label_buf[label_len] = c;
            label_len++;
          end else begin
            dropped_chars = 1'b1;
          end
        end
      endcase
      if (step_bytes.size() > 0) begin
        w = step_bytes.pop_back();
        w.run_last = 1'b1;
        w.packet_end = ends;
        step_bytes.push_back(w);
      end
      if (ends) begin
        label_len = 0;
        in_query = 1'b0;
        dropped_chars = 1'b0;
      end
      foreach (step_bytes[i]) begin
        pending.push_back(step_bytes[i]);
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_byte(logic [7:0] data, logic last, logic [1:0] user);
      wire_byte_t w;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", data));
        return;
      end
      w = pending.pop_front();
      if (data !== w.out_byte) begin
        report_mismatch($sformatf("out_byte %02h, wanted %02h", data, w.out_byte));
      end
      if (last !== w.run_last) begin
        report_mismatch($sformatf("run_last %b, wanted %b", last, w.run_last));
      end
      if (user[0] !== w.packet_end) begin
        report_mismatch($sformatf("packet_end %b, wanted %b", user[0], w.packet_end));
      end
      if (user[1] !== w.label_overflow) begin
        report_mismatch($sformatf("label_overflow %b, wanted %b", user[1],
                                  w.label_overflow));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  dns_query_scoreboard #(NAME_LABEL_MAX) sb;
  bit no_idle = 1'b0;
  int sent_count = 0;

  dns_query_packet_builder_unit #(
    .MAX_LABEL(NAME_LABEL_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= c;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_char(c);
    sent_count++;
  endtask

  // sender holds off until every predicted byte is out and the block is quiet
  task automatic drain_packet_bytes();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_query_id(input logic [15:0] id);
    @(negedge clk);
    cfg_data <= id;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_query_id(id);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == dqb_pkg::DOT_CHAR);
    return c;
  endfunction

  task automatic send_random_query();
    int labels;
    int len;
    int pick;
    labels = $urandom_range(0, 4);
    for (int k = 0; k < labels; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        len = 0;
      end else if (pick == 1) begin
        len = $urandom_range(NAME_LABEL_MAX - 2, NAME_LABEL_MAX + 4);
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int j = 0; j < len; j++) begin
        send_char(label_char());
      end
      // trailing dot now and then
      if (k < labels - 1 || $urandom_range(0, 7) == 0) begin
        send_char(dqb_pkg::DOT_CHAR);
      end
    end
    // stray byte of any value, may break the name
    if ($urandom_range(0, 9) == 0) begin
      send_char(8'($urandom_range(0, 255)));
    end
    send_char(dqb_pkg::END_CHAR);
  endtask

  // output side: random stall per byte, checked at the accepting edge
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  initial begin
    int directed_count;
    int pick;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty name with the reset id
    send_char(dqb_pkg::END_CHAR);
    drain_packet_bytes();
    write_query_id(16'hFFFF);
    // leading dot, extreme characters, two dots in a row
    send_char(dqb_pkg::DOT_CHAR);
    send_char(8'hFF);
    send_char(8'h01);
    send_char(dqb_pkg::DOT_CHAR);
    send_char(dqb_pkg::DOT_CHAR);
    send_char(8'h7F);
    send_char(dqb_pkg::END_CHAR);
    drain_packet_bytes();
    write_query_id(16'h0000);
    // trailing dot, then a one-character name
    send_char(8'h80);
    send_char(dqb_pkg::DOT_CHAR);
    send_char(dqb_pkg::END_CHAR);
    send_char(8'h41);
    send_char(dqb_pkg::END_CHAR);
    drain_packet_bytes();
    write_query_id(16'h8001);
    directed_count = sent_count;

    // one overlong label ended by a dot, another ended by the end of the name
    for (int j = 0; j < NAME_LABEL_MAX + 3; j++) begin
      send_char(label_char());
    end
    send_char(dqb_pkg::DOT_CHAR);
    for (int j = 0; j < NAME_LABEL_MAX + 1; j++) begin
      send_char(label_char());
    end
    send_char(dqb_pkg::END_CHAR);

    while (sent_count < directed_count + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      send_random_query();
      if ($urandom_range(0, 3) == 0) begin
        drain_packet_bytes();
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
          write_query_id(16'h0000);
        end else if (pick == 1) begin
          write_query_id(16'hFFFF);
        end else begin
          write_query_id(16'($urandom_range(0, 65535)));
        end
      end
    end

    no_idle = 1'b0;
    drain_packet_bytes();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dqb_pkg.sv
hw/rtl/dqb_ctrl.sv
hw/rtl/dqb_datapath.sv
hw/rtl/dns_query_packet_builder_unit.sv
test/dns_query_packet_builder_unit_tb.sv
